>>> sv/lnds_pkg.sv
// Shared constants and types for the longest non-decreasing subsequence block.
package lnds_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int VALUE_W      = 32;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        cnt_t                      length;
        idx_t                      pred;
    } entry_t;

endpackage

>>> sv/longest_nondecreasing_subsequence_core.sv
// Longest non-decreasing subsequence core: sample store, compare sequencer and traceback.
// Samples are loaded one item at a time; each accepted sample holds the input stalled while
// it is compared and written (a sample dropped because the store is full is taken at once):
// the single compare unit visits every earlier stored sample once, one stored entry per
// cycle through the store's one read port. An item that carries last_sample then walks the
// predecessor chain back (one store read per element) into a small output buffer and emits
// the subsequence in order. A result register parts the two sides.
module longest_nondecreasing_subsequence_core
    import lnds_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_stall,
    input  logic signed [VALUE_W-1:0] sample,
    input  logic                      last_sample,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic signed [VALUE_W-1:0] kept_value,
    output logic                      kept_last,
    output logic [CNT_W-1:0]          run_length,
    output logic                      dropped_any
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE,
        S_TRACE_RD,
        S_TRACE_WR,
        S_EMIT_RD,
        S_EMIT_LOAD
    } state_t;

    state_t                    state_reg;
    cnt_t                      loaded_reg;
    cnt_t                      best_len_reg;
    idx_t                      best_end_reg;
    logic                      overflow_reg;
    logic signed [VALUE_W-1:0] sample_reg;
    logic                      last_reg;
    idx_t                      j_reg;
    logic                      cmp_valid_reg;
    idx_t                      cmp_idx_reg;
    cnt_t                      len_reg;
    idx_t                      pred_reg;
    idx_t                      idx_reg;
    idx_t                      slot_reg;
    idx_t                      emit_reg;
    logic                      result_valid_reg;
    logic signed [VALUE_W-1:0] kept_value_reg;
    logic                      kept_last_reg;
    cnt_t                      run_length_reg;
    logic                      dropped_any_reg;

    entry_t                    store_mem [MAX_ELEMENTS];
    entry_t                    rd_data_reg;
    logic signed [VALUE_W-1:0] out_buf [MAX_ELEMENTS];
    logic signed [VALUE_W-1:0] buf_data_reg;

    idx_t   rd_addr;
    idx_t   pos;
    cnt_t   loaded_m1;
    cnt_t   best_len_m1;
    idx_t   last_slot;
    cnt_t   cand;
    logic   passes;
    logic   accept;
    logic   result_free;
    logic   store_full;

    assign pos         = loaded_reg[IDX_W-1:0];
    assign loaded_m1   = loaded_reg - cnt_t'(1);
    assign best_len_m1 = best_len_reg - cnt_t'(1);
    assign last_slot   = best_len_m1[IDX_W-1:0];
    assign rd_addr     = (state_reg == S_SCAN) ? j_reg : idx_reg;
    assign cand        = rd_data_reg.length + cnt_t'(1);
    assign passes      = cmp_valid_reg && (sample_reg >= $signed(rd_data_reg.value))
                         && (len_reg < cand);
    assign accept      = sample_valid && !sample_stall;
    assign result_free = !result_valid_reg || !result_stall;
    assign store_full  = (loaded_reg >= cnt_t'(MAX_ELEMENTS));

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign kept_value   = kept_value_reg;
    assign kept_last    = kept_last_reg;
    assign run_length   = run_length_reg;
    assign dropped_any  = dropped_any_reg;

    // Sample store and output buffer: one write and one registered read each per cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
        begin
            store_mem[pos] <= '{value: sample_reg, length: len_reg, pred: pred_reg};
        end
        rd_data_reg <= store_mem[rd_addr];
        if (state_reg == S_TRACE_WR)
        begin
            out_buf[slot_reg] <= $signed(rd_data_reg.value);
        end
        buf_data_reg <= out_buf[emit_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            loaded_reg       <= '0;
            best_len_reg     <= cnt_t'(1);
            best_end_reg     <= '0;
            overflow_reg     <= 1'b0;
            sample_reg       <= '0;
            last_reg         <= 1'b0;
            j_reg            <= '0;
            cmp_valid_reg    <= 1'b0;
            cmp_idx_reg      <= '0;
            len_reg          <= cnt_t'(1);
            pred_reg         <= '0;
            idx_reg          <= '0;
            slot_reg         <= '0;
            emit_reg         <= '0;
            result_valid_reg <= 1'b0;
            kept_value_reg   <= '0;
            kept_last_reg    <= 1'b0;
            run_length_reg   <= '0;
            dropped_any_reg  <= 1'b0;
        end
        else
        begin
            // In S_EMIT_LOAD the result register is reloaded below instead.
            if (result_valid_reg && !result_stall && (state_reg != S_EMIT_LOAD))
            begin
                result_valid_reg <= 1'b0;
            end

            cmp_valid_reg <= (state_reg == S_SCAN);
            cmp_idx_reg   <= j_reg;

            // Shared compare unit: strictly longer runs only, so the earliest predecessor wins.
            if (passes)
            begin
                len_reg  <= cand;
                pred_reg <= cmp_idx_reg;
                if (best_len_reg < cand)
                begin
                    best_len_reg <= cand;
                    best_end_reg <= pos;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        sample_reg <= sample;
                        last_reg   <= last_sample;
                        j_reg      <= '0;
                        len_reg    <= cnt_t'(1);
                        pred_reg   <= '0;
                        if (store_full)
                        begin
                            overflow_reg <= 1'b1;
                            if (last_sample)
                            begin
                                idx_reg   <= best_end_reg;
                                slot_reg  <= last_slot;
                                state_reg <= S_TRACE_RD;
                            end
                        end
                        else if (loaded_reg == '0)
                        begin
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    j_reg <= j_reg + idx_t'(1);
                    if (j_reg == loaded_m1[IDX_W-1:0])
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    loaded_reg <= loaded_reg + cnt_t'(1);
                    if (last_reg)
                    begin
                        idx_reg   <= best_end_reg;
                        slot_reg  <= last_slot;
                        state_reg <= S_TRACE_RD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_TRACE_RD:
                begin
                    state_reg <= S_TRACE_WR;
                end
                S_TRACE_WR:
                begin
                    idx_reg <= rd_data_reg.pred;
                    if (slot_reg == '0)
                    begin
                        emit_reg  <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg - idx_t'(1);
                        state_reg <= S_TRACE_RD;
                    end
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LOAD;
                end
                S_EMIT_LOAD:
                begin
                    if (result_free)
                    begin
                        result_valid_reg <= 1'b1;
                        kept_value_reg   <= buf_data_reg;
                        kept_last_reg    <= (emit_reg == last_slot);
                        run_length_reg   <= best_len_reg;
                        dropped_any_reg  <= overflow_reg;
                        if (emit_reg == last_slot)
                        begin
                            // Sequence done: counters return to their reset values.
                            loaded_reg   <= '0;
                            best_len_reg <= cnt_t'(1);
                            best_end_reg <= '0;
                            overflow_reg <= 1'b0;
                            state_reg    <= S_IDLE;
                        end
                        else
                        begin
                            emit_reg  <= emit_reg + idx_t'(1);
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/lnds_checker.sv
// Port-level checks for the longest non-decreasing subsequence core, bound into the core module.
module lnds_checker
    import lnds_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      sample_valid,
    input logic                      sample_stall,
    input logic signed [VALUE_W-1:0] sample,
    input logic                      last_sample,
    input logic                      result_valid,
    input logic                      result_stall,
    input logic signed [VALUE_W-1:0] kept_value,
    input logic                      kept_last,
    input logic [CNT_W-1:0]          run_length,
    input logic                      dropped_any
);

    logic       out_fire;
    cnt_t       out_cnt_reg;
    cnt_t       rl_reg;
    logic       drop_reg;

    assign out_fire = result_valid && !result_stall;

    // Track the position of each result item within its subsequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= '0;
            rl_reg      <= '0;
            drop_reg    <= 1'b0;
        end
        else if (out_fire)
        begin
            out_cnt_reg <= kept_last ? '0 : out_cnt_reg + cnt_t'(1);
            rl_reg      <= run_length;
            drop_reg    <= dropped_any;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(kept_value)
            && $stable(kept_last) && $stable(run_length) && $stable(dropped_any))
        else $error("stalled result item changed");

    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> run_length != '0 && run_length <= cnt_t'(MAX_ELEMENTS))
        else $error("run_length out of range");

    a_last_on_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> kept_last == (out_cnt_reg == run_length - cnt_t'(1)))
        else $error("kept_last does not match the item count of the subsequence");

    a_same_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && out_cnt_reg != '0 |-> run_length == rl_reg && dropped_any == drop_reg)
        else $error("run_length or dropped_any changed within one subsequence");

endmodule

bind longest_nondecreasing_subsequence_core lnds_checker u_lnds_checker (.*);
